// ===== rtl/hea_pkg.sv =====
// Shared widths, constants, register codes and the arctangent table of the heading block.
package hea_pkg;

	localparam int MAG_W = 16;
	localparam int SUM_W = 18;
	localparam int HEADING_W = 13;
	localparam int ERR_W = 13;
	localparam int DIFF_W = 14;
	localparam int CUM_W = 32;
	localparam int THR_W = 16;
	localparam int CFG_IDX_W = 4;

	// CORDIC datapath: 16 bit average scaled by 2^8, grown by gain and the sqrt(2) corner
	localparam int FINE_SHIFT = 8;
	localparam int CORDIC_W = 27;
	localparam int Z_W = 22;
	localparam int ATAN_LEN = 24;
	localparam int ATAN_IDX_W = 5;

	localparam int FULL_TURN = 5760;
	localparam int HALF_TURN = 2880;
	localparam int FINE_HALF_TURN = 737280;
	localparam int FINE_FULL_TURN = 1474560;

	// Exact division by three for magnitudes below 2^17
	localparam int DIV3_W = 17;
	localparam logic [DIV3_W-1:0] DIV3_RECIP = 17'd43691;

	localparam logic [THR_W-1:0] TURN_THRESHOLD_RESET = 16'd400;
	localparam logic [THR_W-1:0] ALARM_THRESHOLD_RESET = 16'd960;

	localparam logic [CFG_IDX_W-1:0] CFG_TURN_THRESHOLD = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_THRESHOLD = 4'd1;

	// atan(2^-i) in 1/4096 degree, rounded to nearest
	function automatic logic [Z_W-1:0] atan_fine(input logic [ATAN_IDX_W-1:0] idx);
		logic [Z_W-1:0] a;
		case (idx)
			5'd0: a = 22'd184320;
			5'd1: a = 22'd108810;
			5'd2: a = 22'd57492;
			5'd3: a = 22'd29184;
			5'd4: a = 22'd14649;
			5'd5: a = 22'd7331;
			5'd6: a = 22'd3667;
			5'd7: a = 22'd1833;
			5'd8: a = 22'd917;
			5'd9: a = 22'd458;
			5'd10: a = 22'd229;
			5'd11: a = 22'd115;
			5'd12: a = 22'd57;
			5'd13: a = 22'd29;
			5'd14: a = 22'd14;
			5'd15: a = 22'd7;
			5'd16: a = 22'd4;
			5'd17: a = 22'd2;
			5'd18: a = 22'd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/hea_if.sv =====
// Handshake channels of the heading block: samples in, results out, register writes.
interface hea_in_if import hea_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [MAG_W-1:0] mag_x;
	logic signed [MAG_W-1:0] mag_y;
	modport source(output valid, mag_x, mag_y, input ready);
	modport sink(input valid, mag_x, mag_y, output ready);
endinterface

interface hea_out_if import hea_pkg::*; ();
	logic valid;
	logic ready;
	logic [HEADING_W-1:0] heading;
	logic signed [ERR_W-1:0] heading_error;
	logic signed [CUM_W-1:0] error_total;
	logic error_nonnegative;
	logic turn_left;
	logic turn_right;
	logic alarm;
	modport source(output valid, heading, heading_error, error_total, error_nonnegative,
		turn_left, turn_right, alarm, input ready);
	modport sink(input valid, heading, heading_error, error_total, error_nonnegative,
		turn_left, turn_right, alarm, output ready);
endinterface

interface hea_cfg_if import hea_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [THR_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/hea_cordic.sv =====
// Iterative vectoring CORDIC giving the heading of a vector in 1/16 degree units.
module hea_cordic import hea_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [MAG_W-1:0]     ax,
	input  logic signed [MAG_W-1:0]     ay,
	output logic                        done,
	output logic [HEADING_W-1:0]        heading
);

	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int PAD_W = CORDIC_W - MAG_W - FINE_SHIFT;
	localparam int RND_W = Z_W - FINE_SHIFT + 1;

	typedef enum logic [1:0] {C_IDLE, C_ITER, C_WRAP, C_ROUND} cstate_t;

	cstate_t state_q;
	logic signed [CORDIC_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0] z_q;
	logic [Z_W-1:0] total_q;
	logic [STEP_W-1:0] cnt_q;
	logic zero_q;
	logic done_q;
	logic [HEADING_W-1:0] heading_q;

	logic signed [CORDIC_W-1:0] x_init, y_init, dx, dy;
	logic signed [Z_W-1:0] ang;
	logic [Z_W:0] rnd_sum;
	logic [RND_W-1:0] rnd_h, h_wrap;

	assign x_init = {{PAD_W{ax[MAG_W-1]}}, ax, {FINE_SHIFT{1'b0}}};
	assign y_init = {{PAD_W{ay[MAG_W-1]}}, ay, {FINE_SHIFT{1'b0}}};
	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign ang = $signed(atan_fine(ATAN_IDX_W'(cnt_q)));

	// round to 1/16 degree and fold a full turn back to zero
	assign rnd_sum = {1'b0, total_q} + (Z_W+1)'(1 << (FINE_SHIFT - 1));
	assign rnd_h = rnd_sum[Z_W:FINE_SHIFT];
	assign h_wrap = (rnd_h >= RND_W'(FULL_TURN)) ? rnd_h - RND_W'(FULL_TURN) : rnd_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			// pulse done for one cycle as the rounded heading lands
			done_q <= (state_q == C_ROUND);
			case (state_q)
				C_IDLE: begin
					if (start) begin
						zero_q <= (ax == '0) && (ay == '0);
						cnt_q <= '0;
						if (ax[MAG_W-1]) begin
							// turn by half a turn so the vector lies in the right half plane
							x_q <= -x_init;
							y_q <= -y_init;
							z_q <= Z_W'(FINE_HALF_TURN);
						end else begin
							x_q <= x_init;
							y_q <= y_init;
							z_q <= '0;
						end
						state_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (!y_q[CORDIC_W-1]) begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + ang;
					end else begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - ang;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(STEPS - 1)) begin
						state_q <= C_WRAP;
					end
				end
				C_WRAP: begin
					total_q <= z_q[Z_W-1] ? Z_W'(z_q + Z_W'(FINE_FULL_TURN)) : Z_W'(z_q);
					state_q <= C_ROUND;
				end
				C_ROUND: begin
					heading_q <= zero_q ? '0 : h_wrap[HEADING_W-1:0];
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign heading = heading_q;

endmodule

// ===== rtl/heading_error_accumulator.sv =====
// Heading-hold error integrator: sample averaging, CORDIC heading, wrapped error, saturating sum.
// After a group's third sample: divide x, divide y, CORDIC start and wait, error, sum, output register.
// Two samples of a group go back to back; the third holds ready low through the
// shared CORDIC iterations and bookkeeping (which skip the sum and output steps for the
// target group), and longer while an earlier result still waits at the output.
// Reset (arst_n low, asynchronous): sums, target, error sum clear; thresholds 400 and 960.
module heading_error_accumulator import hea_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	hea_in_if.sink      samples,
	hea_out_if.source   results,
	hea_cfg_if.sink     cfg
);

	typedef enum logic [2:0] {
		S_IDLE, S_DIVX, S_DIVY, S_START, S_WAIT, S_ERR, S_ACC, S_EMIT
	} state_t;

	localparam logic signed [DIFF_W-1:0] HALF_S = DIFF_W'(HALF_TURN);
	localparam logic signed [DIFF_W-1:0] FULL_S = DIFF_W'(FULL_TURN);
	localparam int PROD_W = 2 * DIV3_W;
	localparam int WIDE_W = CUM_W + 1;

	state_t state_q;
	logic [1:0] sample_index_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic signed [MAG_W-1:0] avg_x_q, avg_y_q;
	logic [HEADING_W-1:0] head_q;
	logic [HEADING_W-1:0] target_q;
	logic target_valid_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [CUM_W-1:0] error_sum_q;
	logic [THR_W-1:0] turn_thr_q, alarm_thr_q;

	logic out_valid_q;
	logic [HEADING_W-1:0] out_heading_q;
	logic signed [ERR_W-1:0] out_err_q;
	logic signed [CUM_W-1:0] out_cum_q;
	logic out_nonneg_q, out_left_q, out_right_q, out_alarm_q;

	logic cordic_start, cordic_done;
	logic [HEADING_W-1:0] cordic_heading;

	logic in_fire, out_free;
	logic signed [SUM_W-1:0] next_sum_x, next_sum_y;

	// shared divide-by-three: one multiplier, x axis then y axis
	logic signed [SUM_W-1:0] div_sum;
	logic [SUM_W-1:0] div_neg_sum;
	logic [DIV3_W-1:0] div_mag;
	logic [PROD_W-1:0] div_prod;
	logic [MAG_W-1:0] div_q;
	logic signed [MAG_W-1:0] div_avg;

	logic signed [DIFF_W-1:0] diff, diff_wrap;
	logic signed [WIDE_W-1:0] acc_wide;
	logic signed [CUM_W-1:0] acc_sat;
	logic signed [WIDE_W-1:0] cum_wide, turn_wide, alarm_wide, mag_wide;

	assign in_fire = samples.valid && samples.ready;
	assign out_free = !out_valid_q || results.ready;

	assign next_sum_x = sum_x_q + SUM_W'(samples.mag_x);
	assign next_sum_y = sum_y_q + SUM_W'(samples.mag_y);

	assign div_sum = (state_q == S_DIVX) ? sum_x_q : sum_y_q;
	assign div_neg_sum = -div_sum;
	assign div_mag = div_sum[SUM_W-1] ? div_neg_sum[DIV3_W-1:0] : div_sum[DIV3_W-1:0];
	assign div_prod = PROD_W'(div_mag) * PROD_W'(DIV3_RECIP);
	assign div_q = div_prod[DIV3_W+MAG_W-1:DIV3_W];
	assign div_avg = div_sum[SUM_W-1] ? -$signed(div_q) : $signed(div_q);

	// heading minus target, folded into half a turn either way
	assign diff = $signed({1'b0, head_q}) - $signed({1'b0, target_q});
	always_comb begin
		diff_wrap = diff;
		if (diff > HALF_S) begin
			diff_wrap = diff - FULL_S;
		end else if (diff < -HALF_S) begin
			diff_wrap = diff + FULL_S;
		end
	end

	// saturate the running sum at the 32 bit limits
	assign acc_wide = WIDE_W'(error_sum_q) + WIDE_W'(err_q);
	always_comb begin
		case (acc_wide[WIDE_W-1:WIDE_W-2])
			2'b01: acc_sat = {1'b0, {(CUM_W-1){1'b1}}};
			2'b10: acc_sat = {1'b1, {(CUM_W-1){1'b0}}};
			default: acc_sat = acc_wide[CUM_W-1:0];
		endcase
	end

	assign cum_wide = WIDE_W'(error_sum_q);
	assign turn_wide = $signed(WIDE_W'(turn_thr_q));
	assign alarm_wide = $signed(WIDE_W'(alarm_thr_q));
	assign mag_wide = cum_wide[WIDE_W-1] ? -cum_wide : cum_wide;

	assign cordic_start = (state_q == S_START);

	hea_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.ax      (avg_x_q),
		.ay      (avg_y_q),
		.done    (cordic_done),
		.heading (cordic_heading)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sample_index_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			target_q <= '0;
			target_valid_q <= 1'b0;
			error_sum_q <= '0;
			turn_thr_q <= TURN_THRESHOLD_RESET;
			alarm_thr_q <= ALARM_THRESHOLD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			// register writes; indexes past the list are dropped
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_TURN_THRESHOLD: turn_thr_q <= cfg.data;
					CFG_ALARM_THRESHOLD: alarm_thr_q <= cfg.data;
					default: ;
				endcase
			end

			// raise valid as a new item loads, drop it once the sink takes the old one
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						sum_x_q <= next_sum_x;
						sum_y_q <= next_sum_y;
						if (sample_index_q == 2'd2) begin
							sample_index_q <= '0;
							state_q <= S_DIVX;
						end else begin
							sample_index_q <= sample_index_q + 1'b1;
						end
					end
				end
				S_DIVX: begin
					avg_x_q <= div_avg;
					state_q <= S_DIVY;
				end
				S_DIVY: begin
					avg_y_q <= div_avg;
					sum_x_q <= '0;
					sum_y_q <= '0;
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (cordic_done) begin
						head_q <= cordic_heading;
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					if (!target_valid_q) begin
						// first group sets the target and gives no item
						target_q <= head_q;
						target_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						err_q <= diff_wrap[ERR_W-1:0];
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					error_sum_q <= acc_sat;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// hold until the output register is free
					if (out_free) begin
						out_heading_q <= head_q;
						out_err_q <= err_q;
						out_cum_q <= error_sum_q;
						out_nonneg_q <= !error_sum_q[CUM_W-1];
						out_left_q <= cum_wide > turn_wide;
						out_right_q <= cum_wide < -turn_wide;
						out_alarm_q <= mag_wide >= alarm_wide;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign samples.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign results.valid = out_valid_q;
	assign results.heading = out_heading_q;
	assign results.heading_error = out_err_q;
	assign results.error_total = out_cum_q;
	assign results.error_nonnegative = out_nonneg_q;
	assign results.turn_left = out_left_q;
	assign results.turn_right = out_right_q;
	assign results.alarm = out_alarm_q;

endmodule

// ===== rtl/hea_chk.sv =====
// Port-level checks of the heading block, bound to the top level.
module hea_chk import hea_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	hea_in_if.sink      samples,
	hea_out_if.source   results
);

	// a pending item stays valid and holds its error total while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=> results.valid && $stable(results.error_total))
		else $error("result changed while stalled");

	// heading and error stay inside one turn and half a turn
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.heading < 13'(FULL_TURN)) &&
			(results.heading_error <= 13'sd2880) && (results.heading_error >= -13'sd2880))
		else $error("heading or error out of range");

	// side flag follows the sign and the turn flags never both fire
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.error_nonnegative == !results.error_total[CUM_W-1]) &&
			!(results.turn_left && results.turn_right))
		else $error("inconsistent flags");

	// no item appears in the cycle after a sample is taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !$rose(results.valid))
		else $error("result too soon after sample");

endmodule

bind heading_error_accumulator hea_chk u_hea_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.samples (samples),
	.results (results)
);
